// ----- rtl/dtsf_pkg.sv -----
// ----------------------------------------------------------------------------
// dtsf_pkg
// Shared types, sizes and helpers for the depth temporal stability filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dtsf_pkg;

  // Sizes of the pixel store and the sample words.
  localparam int PIXEL_COUNT   = 524288;
  localparam int MAX_SLOTS     = 16;
  localparam int DEPTH_BITS    = 16;
  localparam int ADDR_BITS     = $clog2(PIXEL_COUNT);
  localparam int SLOT_IDX_BITS = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_BITS      = $clog2(MAX_SLOTS + 1);
  localparam int SUM_BITS      = 21;
  localparam int SQ_BITS       = 37;
  localparam int HELD_BITS     = 20;
  localparam int FRAC_BITS     = 4;
  localparam int ROW_BITS      = MAX_SLOTS * DEPTH_BITS;

  // Port field widths.
  localparam int SAMPLE_W = 16;
  localparam int PIXEL_W  = 19;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Mean divider: (sum*32 + count) / (2*count).
  localparam int DIV_BITS  = SUM_BITS + 5;
  localparam int DVSR_BITS = CNT_BITS + 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_THRESHOLD = 4'd0,
    REG_WINDOW_SLOTS     = 4'd1,
    REG_FOLLOW_JUMPS     = 4'd2,
    REG_JUMP_LIMIT       = 4'd3,
    REG_VARIANCE_LIMIT   = 4'd4,
    REG_HYSTERESIS       = 4'd5,
    REG_EMPTY_MARKER     = 4'd6,
    REG_WARMUP_FRAMES    = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] offset_threshold;
    logic [4:0]  window_slots;
    logic        follow_jumps;
    logic [15:0] jump_limit;
    logic [15:0] variance_limit;
    logic [15:0] hysteresis_sixteenths;
    logic [15:0] empty_marker;
    logic [15:0] warmup_frames;
  } cfg_t;

  // One pixel's record in the state memory.
  typedef struct packed {
    logic [MAX_SLOTS-1:0] valid;
    logic [CNT_BITS-1:0]  count;
    logic [SUM_BITS-1:0]  sum;
    logic [SQ_BITS-1:0]   sq;
    logic [HELD_BITS-1:0] held;
    logic                 held_set;
  } rec_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_MIX,
    ST_SQUARE,
    ST_TEST,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // Slots in use: zero acts as one, anything above the ring size as the ring size.
  function automatic logic [CNT_BITS-1:0] slots_in_use(input logic [4:0] w);
    logic [CNT_BITS-1:0] n;
    if (w == 5'd0) begin
      n = CNT_BITS'(1);
    end else if (32'(w) > MAX_SLOTS) begin
      n = CNT_BITS'(MAX_SLOTS);
    end else begin
      n = CNT_BITS'(w);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dtsf_if.sv -----
// ----------------------------------------------------------------------------
// dtsf interfaces
// Valid/ready channels for samples, results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtsf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] depth_sample;
  logic [18:0] pixel_address;
  logic        frame_end;

  modport source (output valid, depth_sample, pixel_address, frame_end, input ready);
  modport sink   (input valid, depth_sample, pixel_address, frame_end, output ready);
endinterface

interface dtsf_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] held_depth;
  logic        pixel_stable;
  logic        warmed_up;

  modport source (output valid, held_depth, pixel_stable, warmed_up, input ready);
  modport sink   (input valid, held_depth, pixel_stable, warmed_up, output ready);
endinterface

interface dtsf_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/depth_temporal_stability_filter.sv -----
// ----------------------------------------------------------------------------
// depth_temporal_stability_filter
// Per-pixel running-window stability filter for a stream of depth samples.
// ----------------------------------------------------------------------------
// After reset the block sweeps its pixel record memory, one record per cycle,
// and accepts no sample word until that pass is done; configuration writes
// are taken at any time. Each sample word is then worked through a
// read-modify-write of its pixel's slot ring and record: five steps (load,
// mix, square, test and finish) when the pixel is not stable, plus the
// bit-serial mean divider between test and finish when it is. The next word
// is taken once the previous one has been written back. The result register
// holds a finished word while the next sample is accepted; a result left
// waiting stalls the write-back.
`default_nettype none

module depth_temporal_stability_filter (
  input  wire logic  clk,
  input  wire logic  rst,
  dtsf_in_if.sink    samples,
  dtsf_out_if.source results,
  dtsf_cfg_if.sink   cfg
);
  import dtsf_pkg::*;

  cfg_t regs;

  // Configuration registers.
  dtsf_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Filter datapath and pixel memories.
  dtsf_core u_core (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .samples (samples),
    .results (results)
  );

endmodule

`default_nettype wire

// ----- rtl/dtsf_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// dtsf_cfg_regs
// Configuration register file, written one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsf_cfg_regs (
  input  wire logic    clk,
  input  wire logic    rst,
  dtsf_cfg_if.sink     cfg,
  output dtsf_pkg::cfg_t regs
);
  import dtsf_pkg::*;

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.offset_threshold      <= 16'd0;
      regs.window_slots          <= 5'd15;
      regs.follow_jumps          <= 1'b0;
      regs.jump_limit            <= 16'd10;
      regs.variance_limit        <= 16'd4;
      regs.hysteresis_sixteenths <= 16'd8;
      regs.empty_marker          <= 16'd4000;
      regs.warmup_frames         <= 16'd60;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_OFFSET_THRESHOLD: regs.offset_threshold      <= cfg.data;
        REG_WINDOW_SLOTS:     regs.window_slots          <= cfg.data[4:0];
        REG_FOLLOW_JUMPS:     regs.follow_jumps          <= cfg.data[0];
        REG_JUMP_LIMIT:       regs.jump_limit            <= cfg.data;
        REG_VARIANCE_LIMIT:   regs.variance_limit        <= cfg.data;
        REG_HYSTERESIS:       regs.hysteresis_sixteenths <= cfg.data;
        REG_EMPTY_MARKER:     regs.empty_marker          <= cfg.data;
        REG_WARMUP_FRAMES:    regs.warmup_frames         <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dtsf_divider.sv -----
// ----------------------------------------------------------------------------
// dtsf_divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsf_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [dtsf_pkg::DIV_BITS-1:0]  dividend,
  input  wire logic [dtsf_pkg::DVSR_BITS-1:0] divisor,
  output logic                               done,
  output logic [dtsf_pkg::DIV_BITS-1:0]      quotient
);
  import dtsf_pkg::*;

  localparam int STEP_BITS = $clog2(DIV_BITS + 1);

  logic                 busy;
  logic [STEP_BITS-1:0] steps;
  logic [DVSR_BITS-1:0] rem;
  logic [DVSR_BITS-1:0] dvsr;
  logic [DVSR_BITS:0]   rem_sh;
  logic                 qbit;
  logic [DVSR_BITS-1:0] rem_next;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh   = {rem, quotient[DIV_BITS-1]};
    qbit     = (rem_sh >= {1'b0, dvsr});
    rem_next = qbit ? DVSR_BITS'(rem_sh - {1'b0, dvsr}) : DVSR_BITS'(rem_sh);
  end

  // The dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == STEP_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvsr     <= divisor;
      rem      <= '0;
      steps    <= STEP_BITS'(DIV_BITS);
    end else if (busy) begin
      quotient <= {quotient[DIV_BITS-2:0], qbit};
      rem      <= rem_next;
      steps    <= steps - STEP_BITS'(1);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dtsf_core.sv -----
// ----------------------------------------------------------------------------
// dtsf_core
// Per-pixel read-modify-write sequencer over the slot and record memories.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsf_core (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire dtsf_pkg::cfg_t regs,
  dtsf_in_if.sink        samples,
  dtsf_out_if.source     results
);
  import dtsf_pkg::*;

  localparam int PROD_BITS = DEPTH_BITS + CNT_BITS;
  localparam int A_BITS    = SQ_BITS + CNT_BITS;
  localparam int S2_BITS   = 2 * SUM_BITS;
  localparam int RHS_BITS  = ((A_BITS > S2_BITS) ? A_BITS : S2_BITS) + 1;

  // Memories: slot rings (never cleared) and per-pixel records (cleared).
  logic [ROW_BITS-1:0] slot_mem [PIXEL_COUNT];
  rec_t                rec_mem  [PIXEL_COUNT];

  state_t state, state_next;

  logic [ROW_BITS-1:0]  slot_rd;
  rec_t                 rec_rd;
  logic [ADDR_BITS-1:0] clr_addr;

  // Item registers.
  logic [DEPTH_BITS-1:0] d_r;
  logic [ADDR_BITS-1:0]  p_r;
  logic                  fe_r;
  logic                  rng_r;
  logic                  take_r;

  // Load stage.
  logic [ROW_BITS-1:0]   row_r;
  rec_t                  rec_r;
  logic [DEPTH_BITS-1:0] old_r;
  logic [PROD_BITS-1:0]  scaled_r;
  logic [PROD_BITS-1:0]  lim_r;
  logic [2*DEPTH_BITS-1:0] dsq_r;
  logic [2*DEPTH_BITS-1:0] osq_r;
  logic                  vbit_r;

  // Mix stage results.
  logic [ROW_BITS-1:0]  row_n;
  logic [MAX_SLOTS-1:0] valid_n;
  logic [CNT_BITS-1:0]  cnt_n;
  logic [SUM_BITS-1:0]  sum_n;
  logic [SQ_BITS-1:0]   sq_n;

  // Square stage.
  logic [A_BITS-1:0]    a_r;
  logic [PROD_BITS-1:0] b_r;
  logic [S2_BITS-1:0]   s2_r;

  logic                 stable_r;
  logic [HELD_BITS-1:0] mean_r;

  // Frame bookkeeping.
  logic [SLOT_IDX_BITS-1:0] ptr;
  logic [15:0]              fc;
  logic                     ready_flag;

  logic [CNT_BITS-1:0] n_slots;
  logic [CNT_BITS-1:0] half_slots;

  // Control strobes.
  logic in_ready;
  logic accept;
  logic slot_we;
  logic rec_we;
  logic fin_go;
  logic div_start;
  logic div_done;
  logic [DIV_BITS-1:0] div_q;

  // Combinational values.
  logic [DEPTH_BITS-1:0] old_c;
  logic                  jump_c;
  logic [PROD_BITS-1:0]  jdiff_c;
  logic [ROW_BITS-1:0]   row_c;
  logic [MAX_SLOTS-1:0]  valid_c;
  logic [CNT_BITS-1:0]   cnt_c;
  logic [SUM_BITS-1:0]   sum_c;
  logic [SQ_BITS-1:0]    sq_c;
  logic [RHS_BITS-1:0]   rhs_c;
  logic                  stable_c;
  logic [HELD_BITS-1:0]  marker16;
  logic [HELD_BITS-1:0]  cur_c;
  logic [HELD_BITS-1:0]  hdiff_c;
  logic                  upd_c;
  logic [HELD_BITS-1:0]  held_c;
  logic                  set_c;
  logic [HELD_BITS-1:0]  shown_c;
  rec_t                  rec_wd;
  logic [SLOT_IDX_BITS:0]   ptr_inc;
  logic [SLOT_IDX_BITS-1:0] ptr_next;
  logic [15:0]              fc_inc;
  logic [15:0]              fc_next;
  logic                     ready_next;

  assign n_slots    = slots_in_use(regs.window_slots);
  assign half_slots = CNT_BITS'((6'(n_slots) + 6'd1) >> 1);
  assign marker16   = {regs.empty_marker, {FRAC_BITS{1'b0}}};

  assign samples.ready = in_ready;
  assign accept        = samples.valid && in_ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_addr == ADDR_BITS'(PIXEL_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_MIX;
      ST_MIX:    state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_TEST;
      ST_TEST:   state_next = stable_c ? ST_DIVIDE : ST_FINISH;
      ST_DIVIDE: if (div_done) state_next = ST_FINISH;
      ST_FINISH: if (fin_go) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready  = 1'b0;
    slot_we   = 1'b0;
    fin_go    = 1'b0;
    div_start = 1'b0;
    rec_we    = 1'b0;
    case (state)
      ST_CLEAR:  rec_we = 1'b1;
      ST_IDLE:   in_ready = 1'b1;
      ST_SQUARE: slot_we = rng_r && take_r;
      ST_TEST:   div_start = stable_c;
      ST_FINISH: begin
        fin_go = !results.valid || results.ready;
        rec_we = fin_go && rng_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clearing sweep over the record memory after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + ADDR_BITS'(1);
    end
  end

  // Memory reads are issued with the accepted word.
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_rd <= slot_mem[ADDR_BITS'(samples.pixel_address)];
      rec_rd  <= rec_mem[ADDR_BITS'(samples.pixel_address)];
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[p_r] <= row_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[(state == ST_CLEAR) ? clr_addr : p_r] <= rec_wd;
    end
  end

  // Capture the accepted word.
  always_ff @(posedge clk) begin
    if (accept) begin
      d_r    <= DEPTH_BITS'(samples.depth_sample);
      p_r    <= ADDR_BITS'(samples.pixel_address);
      fe_r   <= samples.frame_end;
      rng_r  <= (32'(samples.pixel_address) < PIXEL_COUNT);
      take_r <= (DEPTH_BITS'(samples.depth_sample) > DEPTH_BITS'(regs.offset_threshold));
    end
  end

  // Load stage: products for the jump test and the squared terms.
  assign old_c = slot_rd[ptr*DEPTH_BITS +: DEPTH_BITS];

  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      row_r    <= slot_rd;
      rec_r    <= rec_rd;
      old_r    <= old_c;
      vbit_r   <= rec_rd.valid[ptr];
      scaled_r <= PROD_BITS'(d_r) * PROD_BITS'(rec_rd.count);
      lim_r    <= PROD_BITS'(regs.jump_limit) * PROD_BITS'(rec_rd.count);
      dsq_r    <= d_r * d_r;
      osq_r    <= old_c * old_c;
    end
  end

  // Mix stage: jump test and new window statistics.
  always_comb begin
    jdiff_c = (PROD_BITS'(rec_r.sum) >= scaled_r) ? PROD_BITS'(rec_r.sum) - scaled_r
                                                   : scaled_r - PROD_BITS'(rec_r.sum);
    jump_c  = regs.follow_jumps && (rec_r.count != '0) && (jdiff_c >= lim_r);
    row_c   = row_r;
    valid_c = rec_r.valid;
    cnt_c   = rec_r.count;
    sum_c   = rec_r.sum;
    sq_c    = rec_r.sq;
    if (rng_r && take_r) begin
      if (jump_c) begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
          valid_c[i] = (i < 32'(n_slots));
          if (i < 32'(n_slots)) begin
            row_c[i*DEPTH_BITS +: DEPTH_BITS] = d_r;
          end
        end
        cnt_c = n_slots;
        sum_c = SUM_BITS'(d_r) * SUM_BITS'(n_slots);
        sq_c  = SQ_BITS'(dsq_r) * SQ_BITS'(n_slots);
      end else begin
        row_c[ptr*DEPTH_BITS +: DEPTH_BITS] = d_r;
        if (vbit_r) begin
          sum_c = rec_r.sum + SUM_BITS'(d_r) - SUM_BITS'(old_r);
          sq_c  = rec_r.sq + SQ_BITS'(dsq_r) - SQ_BITS'(osq_r);
        end else begin
          cnt_c        = rec_r.count + CNT_BITS'(1);
          sum_c        = rec_r.sum + SUM_BITS'(d_r);
          sq_c         = rec_r.sq + SQ_BITS'(dsq_r);
          valid_c[ptr] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MIX) begin
      row_n   <= row_c;
      valid_n <= valid_c;
      cnt_n   <= cnt_c;
      sum_n   <= sum_c;
      sq_n    <= sq_c;
    end
  end

  // Square stage: terms of the variance test.
  always_ff @(posedge clk) begin
    if (state == ST_SQUARE) begin
      a_r  <= A_BITS'(sq_n) * A_BITS'(cnt_n);
      b_r  <= PROD_BITS'(regs.variance_limit) * PROD_BITS'(cnt_n);
      s2_r <= sum_n * sum_n;
    end
  end

  // Test stage: stable when in range, cnt >= half_slots and sumsq*cnt <= limit*cnt^2 + sum^2.
  always_comb begin
    rhs_c    = RHS_BITS'(b_r) * RHS_BITS'(cnt_n) + RHS_BITS'(s2_r);
    stable_c = rng_r && (cnt_n >= half_slots) && (cnt_n != '0) && (RHS_BITS'(a_r) <= rhs_c);
  end

  always_ff @(posedge clk) begin
    if (state == ST_TEST) begin
      stable_r <= stable_c;
    end
    if (div_done) begin
      mean_r <= HELD_BITS'(div_q);
    end
  end

  // Rounded mean in sixteenths.
  dtsf_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sum_n, 5'd0} + DIV_BITS'(cnt_n)),
    .divisor  ({cnt_n, 1'b0}),
    .done     (div_done),
    .quotient (div_q)
  );

  // Finish stage: hysteresis on the held value and the record write-back.
  always_comb begin
    cur_c   = rec_r.held_set ? rec_r.held : marker16;
    hdiff_c = (mean_r >= cur_c) ? mean_r - cur_c : cur_c - mean_r;
    upd_c   = stable_r && (hdiff_c >= HELD_BITS'(regs.hysteresis_sixteenths));
    held_c  = upd_c ? mean_r : rec_r.held;
    set_c   = rec_r.held_set || upd_c;
    shown_c = set_c ? held_c : marker16;
    if (state == ST_CLEAR) begin
      rec_wd = '0;
    end else begin
      rec_wd = '{valid: valid_n, count: cnt_n, sum: sum_n, sq: sq_n,
                 held: held_c, held_set: set_c};
    end
  end

  // Slot pointer and warm-up counter advance on the frame end.
  always_comb begin
    ptr_inc    = {1'b0, ptr} + (SLOT_IDX_BITS + 1)'(1);
    ptr_next   = ptr;
    fc_inc     = (fc == 16'hFFFF) ? fc : fc + 16'd1;
    fc_next    = fc;
    ready_next = ready_flag;
    if (fe_r) begin
      ptr_next = (CNT_BITS'(ptr_inc) >= n_slots) ? '0 : SLOT_IDX_BITS'(ptr_inc);
      if (!ready_flag) begin
        fc_next    = fc_inc;
        ready_next = (fc_inc > regs.warmup_frames);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      fc         <= '0;
      ready_flag <= 1'b0;
    end else if (fin_go) begin
      ptr        <= ptr_next;
      fc         <= fc_next;
      ready_flag <= ready_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (fin_go) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      results.held_depth   <= rng_r ? shown_c : '0;
      results.pixel_stable <= stable_r;
      results.warmed_up    <= ready_next;
    end
  end

`ifndef SYNTHESIS
  // Only one word is in flight at a time.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready) else $error("word accepted while another in flight");

  // The sample count of an in-range word always matches the number of filled slots.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQUARE && rng_r) |-> (32'(cnt_n) == $countones(valid_n)))
    else $error("sample count disagrees with filled slots");

  // The divider cannot finish in the cycle after it starts.
  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    div_start |=> !div_done) else $error("divider finished too early");

  // Finishing a word presents a result and frees the input.
  a_finish: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> (state == ST_IDLE && results.valid))
    else $error("finished word did not reach the output");
`endif

endmodule

`default_nettype wire
